// ===== hw/rtl/pgct_pkg.sv =====
// Shared types, constants and a helper function for the pixel gray/contrast/threshold unit.
package pgct_pkg;

	// Field widths
	localparam int CHAN_W   = 8;
	localparam int MODE_W   = 2;
	localparam int OFFSET_W = 9;
	localparam int GAIN_W   = 10;
	localparam int CFG_W    = 10;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_GAIN     = 2'd2;

	// Filter mode codes; the unused code behaves as color mode
	localparam logic [MODE_W-1:0] MODE_COLOR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BW    = 2'd2;

	// Luma weights, sum is 256
	localparam int LUMA_R = 77;
	localparam int LUMA_G = 150;
	localparam int LUMA_B = 29;

	// Register limits and reset values
	localparam logic [GAIN_W-1:0]          GAIN_MIN    = 10'd26;
	localparam logic [GAIN_W-1:0]          GAIN_MAX    = 10'd768;
	localparam logic [GAIN_W-1:0]          GAIN_RESET  = 10'd256;
	localparam logic signed [OFFSET_W-1:0] OFFSET_MIN  = -9'sd255;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 9'sd0;

	// Channel arithmetic in units of 1/512 of a level
	localparam int VAL_W = 21;
	localparam logic signed [VAL_W-1:0] HALF_LEVEL_512 = 21'sd65280;
	localparam logic signed [VAL_W-1:0] THRESHOLD_512  = 21'sd65536;
	localparam logic [CHAN_W-1:0]       CHAN_MAX       = 8'd255;

	// Input and output words
	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] alpha_out;
	} pix_out_t;

	// Weighted luma, (77R + 150G + 29B) >> 8.
	function automatic logic [CHAN_W-1:0] luma(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		logic [15:0] acc;
		acc = 16'(LUMA_R) * 16'(r) + 16'(LUMA_G) * 16'(g) + 16'(LUMA_B) * 16'(b);
		return acc[15:8];
	endfunction

endpackage

// ===== hw/rtl/pgct_channel.sv =====
// Contrast, brightness and threshold arithmetic for one color channel.
module pgct_channel (
	input  logic [pgct_pkg::CHAN_W-1:0]          chan,
	input  logic [pgct_pkg::GAIN_W-1:0]          gain,
	input  logic signed [pgct_pkg::OFFSET_W-1:0] offset,
	input  logic                                 bw,
	output logic [pgct_pkg::CHAN_W-1:0]          result
);

	logic signed [pgct_pkg::GAIN_W-1:0]  diff;
	logic signed [pgct_pkg::GAIN_W:0]    gain_s;
	logic signed [pgct_pkg::VAL_W-1:0]   prod;
	logic signed [pgct_pkg::VAL_W-1:0]   off_term;
	logic signed [pgct_pkg::VAL_W-1:0]   val;
	logic [10:0]                         level;

	// Centered channel value 2c - 255, scaled by the gain.
	assign diff     = $signed({1'b0, chan, 1'b0}) - 10'sd255;
	assign gain_s   = $signed({1'b0, gain});
	assign prod     = diff * gain_s;
	assign off_term = {{3{offset[pgct_pkg::OFFSET_W-1]}}, offset, 9'b0};
	assign val      = prod + off_term + pgct_pkg::HALF_LEVEL_512;
	assign level    = val[19:9];

	// Threshold in black-and-white mode, otherwise floor and clamp to 0..255.
	always_comb begin
		if (bw) begin
			result = (val >= pgct_pkg::THRESHOLD_512) ? pgct_pkg::CHAN_MAX : '0;
		end else if (val[pgct_pkg::VAL_W-1]) begin
			result = '0;
		end else if (level > 11'd255) begin
			result = pgct_pkg::CHAN_MAX;
		end else begin
			result = level[7:0];
		end
	end

endmodule

// ===== hw/rtl/pixel_gray_contrast_threshold_unit.sv =====
// Top level of the pixel gray/contrast/threshold unit.
// The unit takes one RGBA pixel word per clock and returns one adjusted word per
// clock when the output is not stalled. An input register (which already holds
// the grayscale values in gray mode) feeds one multiply per channel, and the
// clamped or thresholded result lands in the output register. Back-pressure on
// the output stalls both stages; while a result waits, one more word can still be
// taken into the input register. Configuration takes effect on the next accepted
// word and must only be written while the unit is empty.
module pixel_gray_contrast_threshold_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pgct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pgct_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pgct_pkg::pix_in_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pgct_pkg::pix_out_t               out_data
);

	logic [pgct_pkg::MODE_W-1:0]          filter_mode_q;
	logic signed [pgct_pkg::OFFSET_W-1:0] brightness_offset_q;
	logic [pgct_pkg::GAIN_W-1:0]          contrast_gain_q;

	logic                        valid_s1;
	logic [pgct_pkg::CHAN_W-1:0] red_s1, green_s1, blue_s1, alpha_s1;
	logic                        valid_s2;
	pgct_pkg::pix_out_t          data_s2;

	logic                        adv_s1, adv_s2;
	logic [pgct_pkg::CHAN_W-1:0] gray;
	logic                        bw;
	logic [pgct_pkg::CHAN_W-1:0] red_adj, green_adj, blue_adj;
	logic signed [pgct_pkg::OFFSET_W-1:0] wr_offset;
	logic [pgct_pkg::GAIN_W-1:0]          wr_gain;

	// Written values, saturated to their legal ranges in the registers below.
	assign wr_offset = $signed(cfg_wdata[pgct_pkg::OFFSET_W-1:0]);
	assign wr_gain   = cfg_wdata[pgct_pkg::GAIN_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q       <= pgct_pkg::MODE_COLOR;
			brightness_offset_q <= pgct_pkg::OFFSET_RESET;
			contrast_gain_q     <= pgct_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgct_pkg::REG_FILTER_MODE: begin
					filter_mode_q <= cfg_wdata[pgct_pkg::MODE_W-1:0];
				end
				pgct_pkg::REG_BRIGHTNESS_OFFSET: begin
					brightness_offset_q <= (wr_offset < pgct_pkg::OFFSET_MIN) ?
						pgct_pkg::OFFSET_MIN : wr_offset;
				end
				pgct_pkg::REG_CONTRAST_GAIN: begin
					if (wr_gain < pgct_pkg::GAIN_MIN) begin
						contrast_gain_q <= pgct_pkg::GAIN_MIN;
					end else if (wr_gain > pgct_pkg::GAIN_MAX) begin
						contrast_gain_q <= pgct_pkg::GAIN_MAX;
					end else begin
						contrast_gain_q <= wr_gain;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stall control: a stage moves when the one after it can take its word.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Grayscale replacement happens on the way into the input register.
	assign gray = pgct_pkg::luma(in_data.red_in, in_data.green_in, in_data.blue_in);

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			if (filter_mode_q == pgct_pkg::MODE_GRAY) begin
				red_s1   <= gray;
				green_s1 <= gray;
				blue_s1  <= gray;
			end else begin
				red_s1   <= in_data.red_in;
				green_s1 <= in_data.green_in;
				blue_s1  <= in_data.blue_in;
			end
			alpha_s1 <= in_data.alpha_in;
		end
	end

	// Per-channel adjustment.
	assign bw = (filter_mode_q == pgct_pkg::MODE_BW);

	pgct_channel u_red (
		.chan   (red_s1),
		.gain   (contrast_gain_q),
		.offset (brightness_offset_q),
		.bw     (bw),
		.result (red_adj)
	);

	pgct_channel u_green (
		.chan   (green_s1),
		.gain   (contrast_gain_q),
		.offset (brightness_offset_q),
		.bw     (bw),
		.result (green_adj)
	);

	pgct_channel u_blue (
		.chan   (blue_s1),
		.gain   (contrast_gain_q),
		.offset (brightness_offset_q),
		.bw     (bw),
		.result (blue_adj)
	);

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload, the output register.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2.red_out   <= red_adj;
			data_s2.green_out <= green_adj;
			data_s2.blue_out  <= blue_adj;
			data_s2.alpha_out <= alpha_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== hw/rtl/pgct_checker.sv =====
// Port-level checker for the pixel gray/contrast/threshold unit, with its bind.
module pgct_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  pgct_pkg::pix_out_t   out_data
);

	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count words taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// No word leaves that was never taken in.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> inflight_q != 2'd0)
		else $error("result word without a matching input word");

	// The two stages hold at most two words.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 && !(in_acc && !out_acc && inflight_q == 2'd2))
		else $error("more words in flight than stages");

	// With the output side empty, the unit always takes a word.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

endmodule

bind pixel_gray_contrast_threshold_unit pgct_checker u_pgct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== dv/pixel_gray_contrast_threshold_unit_tb.sv =====
// Self-checking testbench for the pixel gray/contrast/threshold unit.
`timescale 1ns / 1ps

module pixel_gray_contrast_threshold_unit_tb;

	// The spare filter mode code, expected to act as color mode.
	localparam logic [pgct_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int MAX_IDLE = 13;
	localparam int RANDOM_BATCHES = 15;
	localparam int BATCH_WORDS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pgct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pgct_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pgct_pkg::pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pgct_pkg::pix_out_t out_data;

	// Shadow copies of the configuration registers, raw as written.
	logic [pgct_pkg::MODE_W-1:0] mode_reg = pgct_pkg::MODE_COLOR;
	logic signed [pgct_pkg::OFFSET_W-1:0] offset_reg = pgct_pkg::OFFSET_RESET;
	logic [pgct_pkg::GAIN_W-1:0] gain_reg = pgct_pkg::GAIN_RESET;

	// Adjusted pixels still owed by the unit, oldest first.
	pgct_pkg::pix_out_t adjusted_q[$];
	int mismatch_count = 0;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	int rx_hold_cycles = 0;

	pixel_gray_contrast_threshold_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One color channel: contrast about mid-level, offset, then clamp or threshold.
	function automatic logic [pgct_pkg::CHAN_W-1:0] scale_level(
			input logic [pgct_pkg::CHAN_W-1:0] c,
			input int gain, input int ofs, input bit bw);
		int v;
		v = (2 * int'(c) - 255) * gain + int'(pgct_pkg::HALF_LEVEL_512) + 512 * ofs;
		if (bw)
			return (v >= int'(pgct_pkg::THRESHOLD_512)) ? pgct_pkg::CHAN_MAX : '0;
		if (v < 0)
			return '0;
		if ((v >>> 9) > int'(pgct_pkg::CHAN_MAX))
			return pgct_pkg::CHAN_MAX;
		return pgct_pkg::CHAN_W'(v >>> 9);
	endfunction

	// Expected output word for one input word under the current settings.
	function automatic pgct_pkg::pix_out_t adjust_pixel(input pgct_pkg::pix_in_t p);
		int gain;
		int ofs;
		int y;
		bit bw;
		logic [pgct_pkg::CHAN_W-1:0] r, g, b;
		pgct_pkg::pix_out_t o;
		gain = int'(gain_reg);
		ofs = offset_reg;
		if (gain < int'(pgct_pkg::GAIN_MIN))
			gain = int'(pgct_pkg::GAIN_MIN);
		if (gain > int'(pgct_pkg::GAIN_MAX))
			gain = int'(pgct_pkg::GAIN_MAX);
		if (ofs < int'(pgct_pkg::OFFSET_MIN))
			ofs = int'(pgct_pkg::OFFSET_MIN);
		r = p.red_in;
		g = p.green_in;
		b = p.blue_in;
		if (mode_reg == pgct_pkg::MODE_GRAY) begin
			y = (pgct_pkg::LUMA_R * int'(r) + pgct_pkg::LUMA_G * int'(g)
				+ pgct_pkg::LUMA_B * int'(b)) >> 8;
			r = pgct_pkg::CHAN_W'(y);
			g = pgct_pkg::CHAN_W'(y);
			b = pgct_pkg::CHAN_W'(y);
		end
		bw = (mode_reg == pgct_pkg::MODE_BW);
		o.red_out = scale_level(r, gain, ofs, bw);
		o.green_out = scale_level(g, gain, ofs, bw);
		o.blue_out = scale_level(b, gain, ofs, bw);
		o.alpha_out = p.alpha_in;
		return o;
	endfunction

	function automatic pgct_pkg::pix_in_t make_pixel(input int r, input int g, input int b,
			input int a);
		pgct_pkg::pix_in_t p;
		p.red_in = pgct_pkg::CHAN_W'(r);
		p.green_in = pgct_pkg::CHAN_W'(g);
		p.blue_in = pgct_pkg::CHAN_W'(b);
		p.alpha_in = pgct_pkg::CHAN_W'(a);
		return p;
	endfunction

	// Channel values lean toward the extremes now and then.
	function automatic logic [pgct_pkg::CHAN_W-1:0] random_level();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return pgct_pkg::CHAN_MAX;
		return pgct_pkg::CHAN_W'($urandom);
	endfunction

	function automatic void check_field(input string name,
			input logic [pgct_pkg::CHAN_W-1:0] exp_val,
			input logic [pgct_pkg::CHAN_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// Every accepted output word is compared with the oldest expected word.
	always @(posedge clk) begin
		pgct_pkg::pix_out_t exp_word;
		if (arst_n && out_valid && out_ready) begin
			if (adjusted_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, out_data);
				mismatch_count++;
			end else begin
				exp_word = adjusted_q.pop_front();
				check_field("red_out", exp_word.red_out, out_data.red_out);
				check_field("green_out", exp_word.green_out, out_data.green_out);
				check_field("blue_out", exp_word.blue_out, out_data.blue_out);
				check_field("alpha_out", exp_word.alpha_out, out_data.alpha_out);
			end
		end
	end

	// Output side: a random stall before each word, or one long hold when asked.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one word after an optional gap and returns once it is accepted.
	task automatic send_pixel(input pgct_pkg::pix_in_t p);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		adjusted_q.push_back(adjust_pixel(p));
	endtask

	// Stops offering words and waits until every expected word has come out.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (adjusted_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [pgct_pkg::CFG_IDX_W-1:0] idx,
			input logic [pgct_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pgct_pkg::REG_FILTER_MODE: mode_reg = data[pgct_pkg::MODE_W-1:0];
			pgct_pkg::REG_BRIGHTNESS_OFFSET: offset_reg = data[pgct_pkg::OFFSET_W-1:0];
			pgct_pkg::REG_CONTRAST_GAIN: gain_reg = data[pgct_pkg::GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [pgct_pkg::MODE_W-1:0] mode, input int ofs,
			input int gain);
		write_reg(pgct_pkg::REG_FILTER_MODE, pgct_pkg::CFG_W'(mode));
		write_reg(pgct_pkg::REG_BRIGHTNESS_OFFSET,
			pgct_pkg::CFG_W'(pgct_pkg::OFFSET_W'(ofs)));
		write_reg(pgct_pkg::REG_CONTRAST_GAIN, pgct_pkg::CFG_W'(gain));
	endtask

	// Reset settings should give back the input unchanged.
	task automatic test_reset_state();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 255));
		send_pixel(make_pixel(128, 64, 200, 17));
		drain_pipeline();
	endtask

	// Each filter mode, the spare code included, at a non-unity gain.
	task automatic test_filter_modes();
		logic [pgct_pkg::MODE_W-1:0] modes[4];
		int m;
		modes = '{pgct_pkg::MODE_COLOR, pgct_pkg::MODE_GRAY, pgct_pkg::MODE_BW, MODE_SPARE};
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (m = 0; m < 4; m++) begin
			apply_settings(modes[m], 20, 384);
			send_pixel(make_pixel(255, 0, 128, 90));
			send_pixel(make_pixel(30, 200, 127, 255));
			drain_pipeline();
		end
	endtask

	// Gain and offset beyond their limits are saturated; low values clamp at zero.
	task automatic test_register_limits();
		apply_settings(pgct_pkg::MODE_COLOR, -256, 0);
		send_pixel(make_pixel(255, 0, 200, 1));
		send_pixel(make_pixel(128, 127, 255, 254));
		drain_pipeline();
		apply_settings(pgct_pkg::MODE_COLOR, 255, 1023);
		send_pixel(make_pixel(0, 100, 255, 0));
		send_pixel(make_pixel(127, 128, 60, 255));
		drain_pipeline();
		apply_settings(pgct_pkg::MODE_COLOR, -255, 26);
		send_pixel(make_pixel(0, 255, 128, 77));
		drain_pipeline();
		apply_settings(pgct_pkg::MODE_GRAY, -255, 768);
		send_pixel(make_pixel(0, 0, 0, 33));
		send_pixel(make_pixel(255, 255, 255, 200));
		drain_pipeline();
	endtask

	// Black-and-white decision right at the mid-level boundary.
	task automatic test_threshold_edge();
		apply_settings(pgct_pkg::MODE_BW, 0, 256);
		send_pixel(make_pixel(127, 128, 0, 12));
		send_pixel(make_pixel(255, 127, 128, 240));
		drain_pipeline();
	endtask

	// A long output hold while words keep coming, so the input stalls.
	task automatic test_backpressure();
		int k;
		apply_settings(pgct_pkg::MODE_COLOR, -40, 512);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_cycles = 80;
		for (k = 0; k < 30; k++)
			send_pixel(make_pixel(random_level(), random_level(), random_level(), $urandom));
		drain_pipeline();
	endtask

	// Random words in batches, each batch under fresh random settings.
	task automatic test_random_stream();
		int batch, k, pick, ofs, gain;
		logic [pgct_pkg::MODE_W-1:0] mode;
		for (batch = 0; batch < RANDOM_BATCHES; batch++) begin
			mode = pgct_pkg::MODE_W'($urandom_range(0, 3));
			pick = $urandom_range(0, 5);
			case (pick)
				0: ofs = 255;
				1: ofs = -255;
				2: ofs = -256;
				default: ofs = $urandom_range(0, 511) - 256;
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: gain = int'(pgct_pkg::GAIN_MIN);
				1: gain = int'(pgct_pkg::GAIN_MAX);
				2, 3: gain = $urandom_range(0, 1023);
				default: gain = $urandom_range(int'(pgct_pkg::GAIN_MIN),
					int'(pgct_pkg::GAIN_MAX));
			endcase
			// Unused upper bits of the write data are toggled as well.
			write_reg(pgct_pkg::REG_FILTER_MODE,
				{pgct_pkg::CFG_W'($urandom)} & ~pgct_pkg::CFG_W'(3)
				| pgct_pkg::CFG_W'(mode));
			write_reg(pgct_pkg::REG_BRIGHTNESS_OFFSET,
				{1'($urandom), pgct_pkg::OFFSET_W'(ofs)});
			write_reg(pgct_pkg::REG_CONTRAST_GAIN, pgct_pkg::CFG_W'(gain));
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (k = 0; k < BATCH_WORDS; k++)
				send_pixel(make_pixel(random_level(), random_level(), random_level(),
					$urandom));
			drain_pipeline();
		end
	endtask

	initial begin : main_sequence
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_filter_modes();
		test_register_limits();
		test_threshold_edge();
		test_backpressure();
		test_random_stream();
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop in case the unit hangs.
	initial begin : watchdog
		#5000000;
		$display("%0t: timeout with %0d words outstanding", $time, adjusted_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
